>>> src/sfch_pkg.sv
package sfch_pkg;

    localparam logic [7:0]  SYNC_BYTE    = 8'h1B;
    localparam logic [7:0]  END_BYTE     = 8'hFF;
    localparam logic [7:0]  FN_WELD      = 8'h01;
    localparam logic [7:0]  FN_CYCLES    = 8'h02;
    localparam logic [7:0]  FN_SKT       = 8'h03;
    localparam logic [7:0]  FN_IREF      = 8'h04;
    localparam logic [7:0]  FN_TEST      = 8'h41;
    localparam logic [31:0] ACK_PAYLOAD  = 32'h0000_00AA;
    localparam logic [31:0] TEST_PAYLOAD = 32'h4443_4241;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_FUNC  = 3'd1;
    localparam logic [2:0] PH_P0    = 3'd2;
    localparam logic [2:0] PH_P1    = 3'd3;
    localparam logic [2:0] PH_P2    = 3'd4;
    localparam logic [2:0] PH_P3    = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    localparam logic [2:0] FRAME_LAST = 3'd6;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic        reply;
        logic [7:0]  fn;
        logic [31:0] payload;
        logic        start;
        logic [15:0] skt;
        logic [15:0] cycles;
        logic [31:0] iref;
        logic        mode;
        logic        busy;
    } t_desc;

    function automatic logic [7:0] frame_byte(input logic [7:0] fn,
                                              input logic [31:0] payload,
                                              input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = SYNC_BYTE;
            3'd1:    b = fn;
            3'd2:    b = payload[7:0];
            3'd3:    b = payload[15:8];
            3'd4:    b = payload[23:16];
            3'd5:    b = payload[31:24];
            default: b = END_BYTE;
        endcase
        return b;
    endfunction

endpackage

>>> src/sfch_if.sv
interface sfch_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfch_out_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] skt_setting;
    logic [15:0] active_cycles;
    logic [31:0] current_ref_bits;
    logic        weld_mode;
    logic        welding;
    logic        weld_start;

    modport source (output valid, output byte_valid, output tx_byte, output last,
                    output skt_setting, output active_cycles, output current_ref_bits,
                    output weld_mode, output welding, output weld_start, input ready);
    modport sink   (input valid, input byte_valid, input tx_byte, input last,
                    input skt_setting, input active_cycles, input current_ref_bits,
                    input weld_mode, input welding, input weld_start, output ready);
endinterface

>>> src/sfch_core.sv
module sfch_core import sfch_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sfch_in_if.sink i_in,
    output logic   o_desc_valid,
    output t_desc  o_desc,
    input  logic   i_desc_ready
);

    logic        r_in_valid;
    logic        r_kind;
    logic [7:0]  r_byte;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_func,   n_func;
    logic [31:0] r_accum,  n_accum;
    logic [15:0] r_skt,    n_skt;
    logic [15:0] r_cycles, n_cycles;
    logic [31:0] r_iref,   n_iref;
    logic        r_mode,   n_mode;
    logic        r_busy,   n_busy;

    logic        r_desc_valid;
    t_desc       r_desc, n_desc;

    logic        move;

    assign move       = r_in_valid && (!r_desc_valid || i_desc_ready);
    assign i_in.ready = !r_in_valid || move;

    always_comb begin
        n_phase  = r_phase;
        n_func   = r_func;
        n_accum  = r_accum;
        n_skt    = r_skt;
        n_cycles = r_cycles;
        n_iref   = r_iref;
        n_mode   = r_mode;
        n_busy   = r_busy;
        n_desc   = '0;

        if (r_kind == KIND_DONE) begin
            if (r_busy) begin
                n_busy         = 1'b0;
                n_desc.reply   = 1'b1;
                n_desc.fn      = FN_WELD;
                n_desc.payload = ACK_PAYLOAD;
            end
        end else if (!r_busy) begin
            case (r_phase)
                PH_FUNC: begin
                    n_func  = r_byte;
                    n_accum = '0;
                    n_phase = PH_P0;
                end
                PH_P0: begin
                    n_accum[7:0] = r_byte;
                    n_phase      = PH_P1;
                end
                PH_P1: begin
                    n_accum[15:8] = r_byte;
                    n_phase       = PH_P2;
                end
                PH_P2: begin
                    n_accum[23:16] = r_byte;
                    n_phase        = PH_P3;
                end
                PH_P3: begin
                    n_accum[31:24] = r_byte;
                    n_phase        = PH_CHECK;
                end
                PH_CHECK: begin
                    n_phase        = PH_HUNT;
                    n_desc.fn      = r_func;
                    n_desc.payload = ACK_PAYLOAD;
                    case (r_func)
                        FN_TEST: begin
                            n_desc.reply   = 1'b1;
                            n_desc.payload = TEST_PAYLOAD;
                        end
                        FN_SKT: begin
                            n_skt        = r_accum[15:0];
                            n_desc.reply = 1'b1;
                        end
                        FN_IREF: begin
                            n_iref       = r_accum;
                            n_desc.reply = 1'b1;
                        end
                        FN_CYCLES: begin
                            n_cycles     = {r_accum[14:0], 1'b0};
                            n_desc.reply = 1'b1;
                        end
                        FN_WELD: begin
                            if (r_accum == 32'd1) begin
                                n_mode = 1'b0;
                            end else if (r_accum == 32'd2) begin
                                n_mode = 1'b1;
                            end
                            n_busy       = 1'b1;
                            n_desc.start = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    n_phase = (r_byte == SYNC_BYTE) ? PH_FUNC : PH_HUNT;
                end
            endcase
        end

        n_desc.skt    = n_skt;
        n_desc.cycles = n_cycles;
        n_desc.iref   = n_iref;
        n_desc.mode   = n_mode;
        n_desc.busy   = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_desc_valid <= 1'b0;
            r_phase      <= PH_HUNT;
            r_func       <= '0;
            r_accum      <= '0;
            r_skt        <= '0;
            r_cycles     <= '0;
            r_iref       <= '0;
            r_mode       <= 1'b0;
            r_busy       <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (move) begin
                r_desc_valid <= 1'b1;
                r_phase      <= n_phase;
                r_func       <= n_func;
                r_accum      <= n_accum;
                r_skt        <= n_skt;
                r_cycles     <= n_cycles;
                r_iref       <= n_iref;
                r_mode       <= n_mode;
                r_busy       <= n_busy;
            end else if (i_desc_ready) begin
                r_desc_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.rx_byte;
        end
        if (move) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_desc_valid && r_desc.start |-> r_desc.busy && !r_desc.reply)
        else $error("weld start without busy flag");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 3'd7)
        else $error("parser phase out of range");

    a_busy_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_busy && r_kind == KIND_BYTE |=> $stable(r_phase) && r_busy)
        else $error("byte while welding changed parser state");

endmodule

>>> src/sfch_tx.sv
module sfch_tx import sfch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_desc_valid,
    input  t_desc      i_desc,
    output logic       o_desc_ready,
    sfch_out_if.source o_out
);

    logic       r_valid;
    t_desc      r_desc;
    logic [2:0] r_idx;
    logic       is_last;
    logic       done;

    assign is_last      = !r_desc.reply || (r_idx == FRAME_LAST);
    assign done         = r_valid && o_out.ready && is_last;
    assign o_desc_ready = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_desc_ready) begin
            r_valid <= i_desc_valid;
            r_idx   <= '0;
        end else if (o_out.ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_ready && i_desc_valid) begin
            r_desc <= i_desc;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.byte_valid       = r_desc.reply;
    assign o_out.tx_byte          = r_desc.reply ? frame_byte(r_desc.fn, r_desc.payload, r_idx)
                                                 : 8'h00;
    assign o_out.last             = is_last;
    assign o_out.skt_setting      = r_desc.skt;
    assign o_out.active_cycles    = r_desc.cycles;
    assign o_out.current_ref_bits = r_desc.iref;
    assign o_out.weld_mode        = r_desc.mode;
    assign o_out.welding          = r_desc.busy;
    assign o_out.weld_start       = r_desc.start;

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_desc.reply |-> r_idx == 3'd0)
        else $error("status result past first slot");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_idx == 3'd0)
        else $error("frame index not rewound after last byte");

    a_start_welding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_desc.start |-> r_desc.busy && !r_desc.reply)
        else $error("weld start pulse on a reply or while idle");

endmodule

>>> src/sync_framed_command_handler_top.sv
// Framed serial command handler. Each request is either a received byte or a
// weld-finished event. A request enters an input register, is parsed and
// executed into a descriptor register, and its results leave from an output
// stage: one status result, or a seven-byte reply frame (sync, function, four
// payload bytes low first, end byte) with last on the seventh. A request is
// taken every cycle while the output side keeps up; a reply frame holds the
// output for seven accepted results, so a run of replies holds back requests
// at the frame serialiser. Every result carries the settings, weld mode and
// welding flag as they stand after its request.
module sync_framed_command_handler_top import sfch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfch_in_if.sink    i_in,
    sfch_out_if.source o_out
);

    logic  desc_valid;
    logic  desc_ready;
    t_desc desc;

    sfch_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_desc_valid (desc_valid),
        .o_desc       (desc),
        .i_desc_ready (desc_ready)
    );

    sfch_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .o_desc_ready (desc_ready),
        .o_out        (o_out)
    );

endmodule

>>> bench/sfch_reply_checker.sv
module sfch_reply_checker import sfch_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sfch_in_if   i_req,
    sfch_out_if  i_res,
    output int   o_fail_count,
    output int   o_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] skt;
        logic [15:0] cycles;
        logic [31:0] iref;
        logic        mode;
        logic        busy;
        logic        start;
    } t_result;

    t_result owed_results[$];
    int      mismatches = 0;

    logic [2:0]  parse_phase;
    logic [7:0]  frame_fn;
    logic [31:0] frame_param;
    logic [15:0] skt_value;
    logic [15:0] cycles_value;
    logic [31:0] iref_value;
    logic        mode_value;
    logic        busy_value;

    function automatic t_result snapshot(input logic valid, input logic [7:0] b,
                                         input logic last, input logic start);
        t_result r;
        r.byte_valid = valid;
        r.tx_byte    = valid ? b : 8'h00;
        r.last       = last;
        r.skt        = skt_value;
        r.cycles     = cycles_value;
        r.iref       = iref_value;
        r.mode       = mode_value;
        r.busy       = busy_value;
        r.start      = start;
        return r;
    endfunction

    task automatic owe_reply(input logic [7:0] fn, input logic [31:0] payload);
        logic [7:0] frame [7];
        frame = '{SYNC_BYTE, fn, payload[7:0], payload[15:8], payload[23:16],
                  payload[31:24], END_BYTE};
        for (int i = 0; i < 7; i++) begin
            owed_results.push_back(snapshot(1'b1, frame[i], i == 6, 1'b0));
        end
    endtask

    task automatic parse_request(input logic kind, input logic [7:0] rx);
        logic replied;
        logic start;
        replied = 1'b0;
        start   = 1'b0;
        if (kind == KIND_DONE) begin
            if (busy_value) begin
                busy_value = 1'b0;
                owe_reply(FN_WELD, ACK_PAYLOAD);
                replied = 1'b1;
            end
        end else if (!busy_value) begin
            case (parse_phase)
                PH_FUNC: begin
                    frame_fn    = rx;
                    frame_param = '0;
                    parse_phase = PH_P0;
                end
                PH_P0, PH_P1, PH_P2, PH_P3: begin
                    frame_param = frame_param | (32'(rx) << (8 * (parse_phase - PH_P0)));
                    parse_phase = parse_phase + 3'd1;
                end
                PH_CHECK: begin
                    parse_phase = PH_HUNT;
                    replied     = 1'b1;
                    case (frame_fn)
                        FN_TEST: owe_reply(frame_fn, TEST_PAYLOAD);
                        FN_SKT: begin
                            skt_value = frame_param[15:0];
                            owe_reply(frame_fn, ACK_PAYLOAD);
                        end
                        FN_IREF: begin
                            iref_value = frame_param;
                            owe_reply(frame_fn, ACK_PAYLOAD);
                        end
                        FN_CYCLES: begin
                            cycles_value = {frame_param[14:0], 1'b0};
                            owe_reply(frame_fn, ACK_PAYLOAD);
                        end
                        FN_WELD: begin
                            if (frame_param == 32'd1) begin
                                mode_value = 1'b0;
                            end else if (frame_param == 32'd2) begin
                                mode_value = 1'b1;
                            end
                            busy_value = 1'b1;
                            start      = 1'b1;
                            replied    = 1'b0;
                        end
                        default: replied = 1'b0;
                    endcase
                end
                default: parse_phase = (rx == SYNC_BYTE) ? PH_FUNC : PH_HUNT;
            endcase
        end
        if (!replied) begin
            owed_results.push_back(snapshot(1'b0, 8'h00, 1'b1, start));
        end
    endtask

    function automatic string show(input t_result r);
        return $sformatf({"byte_valid=%0d tx_byte=%02h last=%0d skt=%04h cycles=%04h ",
                          "iref=%08h mode=%0d welding=%0d start=%0d"},
                         r.byte_valid, r.tx_byte, r.last, r.skt, r.cycles, r.iref,
                         r.mode, r.busy, r.start);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            parse_phase  = PH_HUNT;
            frame_fn     = '0;
            frame_param  = '0;
            skt_value    = '0;
            cycles_value = '0;
            iref_value   = '0;
            mode_value   = 1'b0;
            busy_value   = 1'b0;
            owed_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.byte_valid = i_res.byte_valid;
                got.tx_byte    = i_res.tx_byte;
                got.last       = i_res.last;
                got.skt        = i_res.skt_setting;
                got.cycles     = i_res.active_cycles;
                got.iref       = i_res.current_ref_bits;
                got.mode       = i_res.weld_mode;
                got.busy       = i_res.welding;
                got.start      = i_res.weld_start;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t unexpected result: %s", $realtime, show(got));
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                parse_request(i_req.kind, i_req.rx_byte);
            end
        end
        o_owed       <= owed_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> bench/tb.sv
module tb import sfch_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int BURST_ITEMS  = 60;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   owed_count;
    int   idle_cycles = 0;
    bit   hold_off_req = 1'b0;

    t_request requests[$];

    sfch_in_if  req_ch ();
    sfch_out_if res_ch ();

    sync_framed_command_handler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    sfch_reply_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_owed       (owed_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic add_byte(input logic [7:0] b);
        requests.push_back('{kind: KIND_BYTE, rx: b});
    endtask

    task automatic add_done();
        requests.push_back('{kind: KIND_DONE, rx: 8'($urandom_range(0, 255))});
    endtask

    task automatic add_frame(input logic [7:0] fn, input logic [31:0] param,
                             input logic [7:0] check);
        add_byte(SYNC_BYTE);
        add_byte(fn);
        for (int i = 0; i < 4; i++) begin
            add_byte(param[8 * i +: 8]);
        end
        add_byte(check);
    endtask

    task automatic build_requests();
        int          counted;
        int          n;
        logic [7:0]  fn;
        logic [31:0] param;
        // idle weld-finished event, noise while hunting
        add_done();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_frame(FN_SKT, 32'hFFFF_FFFF, 8'h00);
        // doubled count wraps at 16 bits
        add_frame(FN_CYCLES, 32'h0000_8001, 8'hFF);
        add_frame(FN_WELD, 32'd2, 8'h5A);
        // dropped while welding, then finish
        add_byte(SYNC_BYTE);
        add_done();

        counted = requests.size();
        while (counted < RANDOM_ITEMS) begin
            n = $urandom_range(0, 99);
            if (n < 70) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: fn = FN_WELD;
                    3:       fn = FN_CYCLES;
                    4:       fn = FN_SKT;
                    5:       fn = FN_IREF;
                    6:       fn = FN_TEST;
                    7:       fn = SYNC_BYTE;
                    default: fn = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 5))
                    0:       param = 32'd0;
                    1:       param = 32'd1;
                    2:       param = 32'd2;
                    3:       param = 32'hFFFF_FFFF;
                    default: param = $urandom;
                endcase
                add_frame(fn, param, 8'($urandom_range(0, 255)));
                counted += 7;
                if (fn == FN_WELD) begin
                    n = $urandom_range(0, 2);
                    repeat (n) add_byte(8'($urandom_range(0, 255)));
                    counted += n;
                    if ($urandom_range(0, 9) != 0) begin
                        add_done();
                        counted++;
                    end
                end
            end else if (n < 85) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_done();
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                end
                counted++;
            end else begin
                // truncated frame
                add_byte(SYNC_BYTE);
                n = $urandom_range(0, 4);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
                counted += n + 1;
            end
        end
    endtask

    // request side
    initial begin
        int gap;
        int burst_at;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_BYTE;
        req_ch.rx_byte <= 8'h00;
        res_ch.ready   <= 1'b0;
        build_requests();
        burst_at = requests.size() / 2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int idx = 0; idx < requests.size(); idx++) begin
            if (idx == burst_at) begin
                hold_off_req = 1'b1;
            end
            if ((idx >= burst_at && idx < burst_at + BURST_ITEMS) || (idx / 50) % 4 == 3) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 13);
            end
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            req_ch.valid   <= 1'b1;
            req_ch.kind    <= requests[idx].kind;
            req_ch.rx_byte <= requests[idx].rx;
            do @(posedge i_clk); while (!req_ch.ready);
        end
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && owed_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // result side
    initial begin
        int gap;
        int n_results;
        n_results = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end else if ((n_results / 60) % 4 == 2) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 13);
            end
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> filelist.f
src/sfch_pkg.sv
src/sfch_if.sv
src/sfch_core.sv
src/sfch_tx.sv
src/sync_framed_command_handler_top.sv
bench/sfch_reply_checker.sv
bench/tb.sv
